FILE: src/line_sensor_weighted_centroid_unit_assert.svh
// Assertion macros used by the checker of the line sensor centroid unit.
`ifndef LINE_SENSOR_WEIGHTED_CENTROID_UNIT_ASSERT_SVH
`define LINE_SENSOR_WEIGHTED_CENTROID_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define LSWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define LSWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lswc_pkg.sv
// Shared types and constants of the line sensor weighted centroid unit.
package lswc_pkg;

    // Number of inner sensors that take part in the centroid.
    localparam int SENSOR_COUNT = 6;

    // Default reading width of one sensor.
    localparam int DEF_SAMPLE_BITS = 8;

    // Width of a position weight and of the line position.
    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 16;

    // The quotient magnitude always stays below 2**15.
    localparam int QUO_BITS = 15;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_ONE   = 3'd0,
        CFG_WEIGHT_TWO   = 3'd1,
        CFG_WEIGHT_THREE = 3'd2,
        CFG_WEIGHT_FOUR  = 3'd3,
        CFG_WEIGHT_FIVE  = 3'd4,
        CFG_WEIGHT_SIX   = 3'd5
    } t_cfg_index;

    // Weight values after reset, first inner sensor first.
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET [SENSOR_COUNT] = '{
        -16'sd10000, -16'sd6000, -16'sd2000, 16'sd2000, 16'sd6000, 16'sd10000
    };

endpackage

FILE: src/line_sensor_weighted_centroid_unit.sv
// Top level of the line sensor weighted centroid unit: position = sum(w*s) / (1 + sum(s)).
//
//  Channel   Direction  Handshake                  Beat contents
//  s_axis    in         i_s_axis_tvalid/o_..tready one frame of six sensor readings
//  m_axis    out        o_m_axis_tvalid/i_..tready one signed line position
//  cfg       in         i_cfg_valid/o_cfg_ready    weight register index and value
//
// A frame is accepted every cycle unless both output buffer entries are full.
// A result passes the 15 quotient stages, one restoring step per stage, after the
// four stages of multiply, add, add and magnitude, and then the output buffer register.
// Reset (synchronous, active low) empties the pipeline and loads the default weights.
// A two-entry output buffer keeps the input open while one result waits; the
// pipeline halts only when both entries are full, and nothing is lost or repeated.
module line_sensor_weighted_centroid_unit #(
    parameter int SAMPLE_BITS = lswc_pkg::DEF_SAMPLE_BITS,
    localparam int IN_DATA_W  = ((lswc_pkg::SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input frame.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // From bit 0: sample_one, sample_two, ..., sample_six, zero padding.
    input  logic [IN_DATA_W-1:0]          i_s_axis_tdata,
    // Result.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // From bit 0: line_position.
    output logic [lswc_pkg::POS_W-1:0]    o_m_axis_tdata,
    // Configuration writes.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lswc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lswc_pkg::WEIGHT_W-1:0] i_cfg_data
);

    localparam int NS      = lswc_pkg::SENSOR_COUNT;
    localparam int QB      = lswc_pkg::QUO_BITS;
    localparam int PROD_W  = lswc_pkg::WEIGHT_W + SAMPLE_BITS + 1;
    localparam int WSUM_W  = PROD_W + 3;
    localparam int TOT_W   = SAMPLE_BITS + 3;
    localparam int MAG_W   = WSUM_W;
    localparam int STAGES  = 4 + QB;

    // Weight registers.
    logic signed [lswc_pkg::WEIGHT_W-1:0] r_weight [NS];

    // Pipeline control.
    logic              w_en;
    logic [STAGES-1:0] r_vld;

    // Front stages: products, pair sums, full sum, magnitude.
    logic signed [PROD_W-1:0] r_prod [NS];
    logic [TOT_W-1:0]         r_tot1;
    logic signed [WSUM_W-1:0] r_pair [NS/2];
    logic [TOT_W-1:0]         r_tot2;
    logic signed [WSUM_W-1:0] r_wsum;
    logic [TOT_W-1:0]         r_tot3;
    logic [MAG_W-1:0]         r_mag;
    logic [TOT_W-1:0]         r_dvs0;
    logic                     r_neg0;

    // Divider stages.
    logic [MAG_W-1:0] r_rem [QB];
    logic [TOT_W-1:0] r_dvs [QB];
    logic [QB-1:0]    r_quo [QB];
    logic             r_neg [QB];

    // Output buffer.
    logic [1:0]                  r_count;
    logic [lswc_pkg::POS_W-1:0]  r_buf0;
    logic [lswc_pkg::POS_W-1:0]  r_buf1;
    logic [lswc_pkg::POS_W-1:0]  n_pos;
    logic                        w_push;
    logic                        w_pop;

    logic signed [PROD_W-1:0] n_prod [NS];
    logic [TOT_W-1:0]         n_tot;

    // The pipeline moves unless both output buffer entries are taken.
    assign w_en            = (r_count != 2'd2);
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // Weight register writes; indexes past the last weight are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_weight[k] <= lswc_pkg::WEIGHT_RESET[k];
            end
        end else if (i_cfg_valid && (i_cfg_index <= lswc_pkg::CFG_WEIGHT_SIX)) begin
            r_weight[i_cfg_index] <= i_cfg_data;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_s_axis_tvalid};
        end
    end

    // Stage 1: one multiplier per sensor, and the reading sum plus one.
    always_comb begin
        n_tot = TOT_W'(1);
        for (int k = 0; k < NS; k++) begin
            n_prod[k] = $signed(r_weight[k]) *
                        $signed({1'b0, i_s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]});
            n_tot     = n_tot + TOT_W'(i_s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= n_prod;
            r_tot1 <= n_tot;
        end
    end

    // Stage 2: sum the products in pairs.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int m = 0; m < NS / 2; m++) begin
                r_pair[m] <= WSUM_W'(r_prod[2*m]) + WSUM_W'(r_prod[2*m+1]);
            end
            r_tot2 <= r_tot1;
        end
    end

    // Stage 3: full weighted sum.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wsum <= r_pair[0] + r_pair[1] + r_pair[2];
            r_tot3 <= r_tot2;
        end
    end

    // Stage 4: split the weighted sum into sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg0 <= r_wsum[WSUM_W-1];
            r_mag  <= r_wsum[WSUM_W-1] ? MAG_W'(-r_wsum) : MAG_W'(r_wsum);
            r_dvs0 <= r_tot3;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    // The magnitude is below divisor * 2**15, so 15 steps settle the quotient.
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;
        logic [MAG_W-1:0] w_rem_in;
        logic [TOT_W-1:0] w_dvs_in;
        logic [QB-1:0]    w_quo_in;
        logic             w_neg_in;
        logic [MAG_W-1:0] w_shift;
        logic [MAG_W-1:0] n_rem;
        logic [QB-1:0]    n_quo;

        if (j == 0) begin : g_first
            assign w_rem_in = r_mag;
            assign w_dvs_in = r_dvs0;
            assign w_quo_in = '0;
            assign w_neg_in = r_neg0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_dvs_in = r_dvs[j-1];
            assign w_quo_in = r_quo[j-1];
            assign w_neg_in = r_neg[j-1];
        end

        assign w_shift = MAG_W'(w_dvs_in) << BIT;

        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (w_rem_in >= w_shift) begin
                n_rem      = w_rem_in - w_shift;
                n_quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[j] <= n_rem;
                r_dvs[j] <= w_dvs_in;
                r_quo[j] <= n_quo;
                r_neg[j] <= w_neg_in;
            end
        end
    end

    // Apply the sign to the quotient; this truncates toward zero.
    assign n_pos = r_neg[QB-1] ? (-{1'b0, r_quo[QB-1]}) : {1'b0, r_quo[QB-1]};

    // Two-entry output buffer; entry 0 is the beat on the output.
    assign w_push = w_en && r_vld[STAGES-1];
    assign w_pop  = (r_count != 2'd0) && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_count)
            2'd0: begin
                if (w_push) begin
                    r_buf0 <= n_pos;
                end
            end
            2'd1: begin
                if (w_push && w_pop) begin
                    r_buf0 <= n_pos;
                end else if (w_push) begin
                    r_buf1 <= n_pos;
                end
            end
            default: begin
                if (w_pop) begin
                    r_buf0 <= r_buf1;
                end
            end
        endcase
    end

    assign o_m_axis_tvalid = (r_count != 2'd0);
    assign o_m_axis_tdata  = r_buf0;

endmodule

FILE: src/lswc_checker.sv
// Port-level checker of the line sensor weighted centroid unit and its bind.
`include "line_sensor_weighted_centroid_unit_assert.svh"

module lswc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [lswc_pkg::POS_W-1:0]   o_m_axis_tdata
);

    // No result is offered in the cycle after a reset edge.
    `LSWC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result after reset")

    // A stalled result beat stays offered with the same data.
    `LSWC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // The input closes only while the output buffer is full, so a result waits.
    `LSWC_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid, "input stalled with no result waiting")

    // The buffer fills only if the waiting result was not taken.
    `LSWC_ASSERT(a_fill_cause, i_clk, i_rst_n, $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready), "buffer filled while output drained")

endmodule

bind line_sensor_weighted_centroid_unit lswc_checker u_lswc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: bench/tb_line_sensor_weighted_centroid_unit.sv
// Self-checking bench for the line sensor centroid unit: directed frames, then random frames.
module tb_line_sensor_weighted_centroid_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS  = lswc_pkg::DEF_SAMPLE_BITS;
    localparam int IN_DATA_W    = ((lswc_pkg::SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int PIPE_LATENCY = 20;
    localparam int PHASE_FRAMES = 220;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 3000;
    localparam int REPORT_LIMIT = 200;
    localparam int DIR_ROWS     = 20;

    // Indexes that name no register; writes to them must leave the weights alone.
    localparam logic [lswc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
    localparam logic [lswc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

    typedef logic [lswc_pkg::SENSOR_COUNT-1:0][SAMPLE_BITS-1:0]       t_frame;
    typedef logic [lswc_pkg::SENSOR_COUNT-1:0][lswc_pkg::WEIGHT_W-1:0] t_weight_set;
    typedef enum {WSET_RESET, WSET_MIN, WSET_MAX} t_wset;

    typedef struct {
        t_wset                             wset;
        t_frame                            samples;
        bit                                has_known;
        logic signed [lswc_pkg::POS_W-1:0] known;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [IN_DATA_W-1:0]            i_s_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [lswc_pkg::POS_W-1:0]      o_m_axis_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [lswc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lswc_pkg::WEIGHT_W-1:0]   i_cfg_data;

    // Predictor state and scoreboard.
    t_weight_set                 weight_regs;
    t_weight_set                 reset_weights;
    logic [lswc_pkg::POS_W-1:0]  pending_positions [$];
    int                          mismatch_count = 0;
    bit                          send_gaps = 1'b0;
    bit                          recv_gaps = 1'b0;
    bit                          hold_req  = 1'b0;
    bit                          hold_off  = 1'b0;

    // Directed frames; samples are listed sixth sensor first.
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{WSET_RESET, {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, 16'sd0},
        '{WSET_RESET, {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, 16'sd0},
        '{WSET_RESET, {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, -16'sd9960},
        '{WSET_RESET, {8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, 16'sd9960},
        '{WSET_RESET, {8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0  }, 1'b1, -16'sd5976},
        '{WSET_RESET, {8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, 16'sd5976},
        '{WSET_RESET, {8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0  }, 1'b1, -16'sd1992},
        '{WSET_RESET, {8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0  }, 1'b1, 16'sd1992},
        '{WSET_RESET, {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1  }, 1'b1, -16'sd5000},
        '{WSET_RESET, {8'd6,   8'd5,   8'd4,   8'd3,   8'd2,   8'd1  }, 1'b0, 16'sd0},
        '{WSET_RESET, {8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  8'h55 }, 1'b0, 16'sd0},
        '{WSET_RESET, {8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA }, 1'b0, 16'sd0},
        '{WSET_RESET, {8'd0,   8'd0,   8'd0,   8'd0,   8'd127, 8'd128}, 1'b0, 16'sd0},
        '{WSET_MIN,   {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, -16'sd32640},
        '{WSET_MIN,   {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, -16'sd32746},
        '{WSET_MIN,   {8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255}, 1'b0, 16'sd0},
        '{WSET_MAX,   {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, 16'sd32745},
        '{WSET_MAX,   {8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, 16'sd32639},
        '{WSET_MAX,   {8'd0,   8'd0,   8'd0,   8'd1,   8'd0,   8'd0  }, 1'b1, 16'sd16383},
        '{WSET_MAX,   {8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0  }, 1'b0, 16'sd0}
    };

    line_sensor_weighted_centroid_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Weighted sum over one plus the reading sum, truncated toward zero.
    function automatic logic [lswc_pkg::POS_W-1:0] centroid_of(t_frame s);
        longint weighted;
        longint total;
        weighted = 0;
        total    = 1;
        for (int k = 0; k < lswc_pkg::SENSOR_COUNT; k++) begin
            weighted += longint'($signed(weight_regs[k])) * longint'(s[k]);
            total    += longint'(s[k]);
        end
        return lswc_pkg::POS_W'(weighted / total);
    endfunction

    // Wait before the next beat: none when gaps are off, otherwise often none and else a random wait.
    function automatic int draw_gap(bit enabled);
        if (!enabled || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Mostly fully random frames, plus line-like frames under two adjacent sensors and flat ones.
    function automatic t_frame random_frame();
        t_frame s;
        int     c;
        s = '0;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = '1;
            2, 3, 4: begin
                c = $urandom_range(0, lswc_pkg::SENSOR_COUNT - 2);
                s[c]     = SAMPLE_BITS'($urandom);
                s[c + 1] = SAMPLE_BITS'($urandom);
            end
            default: begin
                for (int k = 0; k < lswc_pkg::SENSOR_COUNT; k++) begin
                    s[k] = SAMPLE_BITS'($urandom);
                end
            end
        endcase
        return s;
    endfunction

    // Random weights with the occasional extreme value.
    function automatic t_weight_set random_weights();
        t_weight_set w;
        for (int k = 0; k < lswc_pkg::SENSOR_COUNT; k++) begin
            case ($urandom_range(0, 7))
                0: w[k] = 16'h8000;
                1: w[k] = 16'h7FFF;
                default: w[k] = lswc_pkg::WEIGHT_W'($urandom);
            endcase
        end
        return w;
    endfunction

    // One register write; the predictor follows it at the accepting edge.
    task automatic cfg_write(logic [lswc_pkg::CFG_IDX_W-1:0] idx,
                             logic [lswc_pkg::WEIGHT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx < lswc_pkg::SENSOR_COUNT) begin
            weight_regs[idx] = data;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_weights(t_weight_set w);
        for (int k = 0; k < lswc_pkg::SENSOR_COUNT; k++) begin
            cfg_write(lswc_pkg::t_cfg_index'(k), w[k]);
        end
    endtask

    // Offers one frame and records its expected position once the beat is taken.
    task automatic send_frame(t_frame s, bit has_known, logic [lswc_pkg::POS_W-1:0] known);
        int gap;
        gap = draw_gap(send_gaps);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = IN_DATA_W'(s);
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        pending_positions.push_back(has_known ? known : centroid_of(s));
    endtask

    // Stops sending and waits until every expected position has come out.
    task automatic await_idle();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_positions.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_positions.size() != 0) begin
            $display("%0t: %0d expected line positions never arrived, next expected %0d",
                     $time, pending_positions.size(), $signed(pending_positions[0]));
            mismatch_count += pending_positions.size();
            pending_positions.delete();
        end
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
    endtask

    // One random phase: optional writes to unused indexes, new weights, then frames.
    task automatic run_phase(bit spare, t_weight_set w, bit sg, bit rg, bit squeeze);
        await_idle();
        if (spare) begin
            cfg_write(CFG_SPARE_LOW, lswc_pkg::WEIGHT_W'($urandom));
            cfg_write(CFG_SPARE_HIGH, lswc_pkg::WEIGHT_W'($urandom));
        end
        apply_weights(w);
        send_gaps = sg;
        recv_gaps = rg;
        hold_req  = squeeze;
        repeat (PHASE_FRAMES) send_frame(random_frame(), 1'b0, '0);
    endtask

    // Long receiver hold-off so the output buffer fills and the input stalls.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Result side: random stalls, each beat checked against the oldest expectation.
    initial begin
        int                         stall_left;
        logic [lswc_pkg::POS_W-1:0] expected;
        stall_left      = 0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = (stall_left == 0) && !hold_off;
            @(posedge i_clk);
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                if (pending_positions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected line position, expected none, got %0d",
                                 $time, $signed(o_m_axis_tdata));
                    end
                end else begin
                    expected = pending_positions.pop_front();
                    if (o_m_axis_tdata !== expected) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: line_position mismatch, expected %0d, got %0d",
                                     $time, $signed(expected), $signed(o_m_axis_tdata));
                        end
                    end
                end
                stall_left = draw_gap(recv_gaps);
            end else if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // Run limit far above the slowest correct run.
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // Reset, directed frames, then random phases over several weight settings.
    initial begin
        t_wset       cur_set;
        t_weight_set min_weights;
        t_weight_set max_weights;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = lswc_pkg::CFG_WEIGHT_ONE;
        i_cfg_data      = '0;
        for (int k = 0; k < lswc_pkg::SENSOR_COUNT; k++) begin
            reset_weights[k] = lswc_pkg::WEIGHT_RESET[k];
            min_weights[k]   = 16'h8000;
            max_weights[k]   = 16'h7FFF;
        end
        weight_regs = reset_weights;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part; the weights change only between groups of rows.
        cur_set   = WSET_RESET;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed_rows[r].wset != cur_set) begin
                await_idle();
                cur_set = directed_rows[r].wset;
                apply_weights(cur_set == WSET_MIN ? min_weights : max_weights);
            end
            send_frame(directed_rows[r].samples, directed_rows[r].has_known,
                       directed_rows[r].known);
        end

        // Random part.
        run_phase(1'b0, max_weights,      1'b1, 1'b1, 1'b0);
        run_phase(1'b1, random_weights(), 1'b0, 1'b0, 1'b0);
        run_phase(1'b0, random_weights(), 1'b1, 1'b0, 1'b1);
        run_phase(1'b0, min_weights,      1'b0, 1'b1, 1'b0);
        run_phase(1'b1, random_weights(), 1'b1, 1'b1, 1'b0);
        run_phase(1'b0, reset_weights,    1'b1, 1'b1, 1'b0);
        run_phase(1'b1, random_weights(), 1'b0, 1'b1, 1'b0);
        await_idle();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/lswc_pkg.sv
src/line_sensor_weighted_centroid_unit.sv
src/lswc_checker.sv
bench/tb_line_sensor_weighted_centroid_unit.sv
